// ===== hw/rtl/char_lcd_nibble_writer_top_macros.svh =====
// Assertion macros shared by the checker of the character LCD nibble writer.
`ifndef CHAR_LCD_NIBBLE_WRITER_TOP_MACROS_SVH
`define CHAR_LCD_NIBBLE_WRITER_TOP_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CLNW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition that must never be seen outside reset.
`define CLNW_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== hw/rtl/clnw_pkg.sv =====
// Package with the types, codes and byte tables of the character LCD nibble writer.
`timescale 1ns / 1ps

package clnw_pkg;

    // Command codes carried in the input tuser.
    typedef enum logic [1:0] {
        ACT_INIT  = 2'd0,
        ACT_PUT   = 2'd1,
        ACT_GOTO  = 2'd2,
        ACT_GLYPH = 2'd3
    } action_t;

    // Controller states.
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EMIT = 1'b1
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic advance;
    } clnw_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;
    } clnw_status_t;

    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 16;
    localparam int CNT_W      = 5;

    // LCD instruction bytes.
    localparam logic [7:0] DDRAM_BASE = 8'h80;
    localparam logic [7:0] CGRAM_BASE = 8'h40;
    localparam logic [7:0] ROW_STRIDE = 8'h40;

    // Strobes per command.
    localparam logic [CNT_W-1:0] INIT_STROBES  = 5'd12;
    localparam logic [CNT_W-1:0] PUT_STROBES   = 5'd2;
    localparam logic [CNT_W-1:0] GOTO_STROBES  = 5'd2;
    localparam logic [CNT_W-1:0] GLYPH_STROBES = 5'd18;

    // Init sequence: function set three times, 4-bit two-line mode,
    // display on, clear display.
    function automatic logic [7:0] init_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = 8'h20;
            3'd1:    b = 8'h20;
            3'd2:    b = 8'h20;
            3'd3:    b = 8'h28;
            3'd4:    b = 8'h0C;
            3'd5:    b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Number of strobes a command produces.
    function automatic logic [CNT_W-1:0] strobe_count(input action_t act);
        logic [CNT_W-1:0] n;
        unique case (act)
            ACT_INIT:  n = INIT_STROBES;
            ACT_PUT:   n = PUT_STROBES;
            ACT_GOTO:  n = GOTO_STROBES;
            ACT_GLYPH: n = GLYPH_STROBES;
            default:   n = PUT_STROBES;
        endcase
        return n;
    endfunction

endpackage

// ===== hw/rtl/char_lcd_nibble_writer_top.sv =====
// The first strobe word is offered in the cycle after the command word is accepted.
// Each command gives its full strobe count before the input is ready for the next one:
// 12 strobes for init, 2 for put character and goto, 18 for set glyph.
// The strobe counter in the datapath counts them, one nibble per output handshake.
// Reset clears the controller to idle and the tracked cursor to column 0, row 0.
`timescale 1ns / 1ps

module char_lcd_nibble_writer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata: char_code[7:0], col[13:8], row[15:14], glyph_slot[18:16],
    // glyph_bitmap[82:19], zero pad[87:83]
    input  logic [87:0] s_tdata,
    // s_tuser: action[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: nibble[3:0], long_wait[4], cursor_col[12:5], cursor_row[14:13],
    // zero pad[15]
    output logic [15:0] m_tdata,
    // m_tuser: reg_select[0]
    output logic        m_tuser,
    // m_tlast: last strobe of the command
    output logic        m_tlast
);
    import clnw_pkg::*;

    clnw_cmd_t    cmd;
    clnw_status_t status;

    // Handshake sequencing.
    clnw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    // Byte tables, strobe counter and cursor tracking.
    clnw_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .status  (status),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule

// ===== hw/rtl/clnw_ctrl.sv =====
// Controller state machine of the character LCD nibble writer.
`timescale 1ns / 1ps

module clnw_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output clnw_pkg::clnw_cmd_t    cmd,
    input  clnw_pkg::clnw_status_t status
);
    import clnw_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and command outputs.
    always_comb
    begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        cmd.load    = 1'b0;
        cmd.advance = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    if (status.last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/clnw_datapath.sv =====
// Datapath of the character LCD nibble writer: item latch, strobe counter and cursor.
`timescale 1ns / 1ps

module clnw_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  clnw_pkg::clnw_cmd_t                  cmd,
    output clnw_pkg::clnw_status_t               status,
    input  logic [clnw_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic [1:0]                          s_tuser,
    output logic [clnw_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tuser,
    output logic                                m_tlast
);
    import clnw_pkg::*;

    // Input word fields.
    logic [7:0]  in_char;
    logic [5:0]  in_col;
    logic [1:0]  in_row;
    logic [2:0]  in_slot;
    logic [63:0] in_bitmap;
    action_t     in_action;

    assign in_char   = s_tdata[7:0];
    assign in_col    = s_tdata[13:8];
    assign in_row    = s_tdata[15:14];
    assign in_slot   = s_tdata[18:16];
    assign in_bitmap = s_tdata[82:19];
    assign in_action = action_t'(s_tuser);

    // Latched command payload.
    action_t          action_reg;
    logic [7:0]       char_reg;
    logic [7:0]       adr_reg;
    logic [2:0]       slot_reg;
    logic [63:0]      bitmap_reg;
    logic [CNT_W-1:0] total_reg;

    // Strobe counter and tracked cursor.
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [7:0]       cur_col_reg;
    logic [7:0]       cur_col_next;
    logic [1:0]       cur_row_reg;
    logic [1:0]       cur_row_next;

    // DDRAM address for goto, with 8-bit wrap for out-of-range positions.
    logic [7:0] goto_adr;
    logic [1:0] row_m1;

    assign row_m1   = in_row - 2'd1;
    assign goto_adr = DDRAM_BASE + {row_m1, 6'd0} + {2'b00, in_col} - 8'd1;

    // Payload latch, no reset needed.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= in_action;
            char_reg   <= in_char;
            adr_reg    <= goto_adr;
            slot_reg   <= in_slot;
            bitmap_reg <= in_bitmap;
            total_reg  <= strobe_count(in_action) - 5'd1;
        end
    end

    // Counter and cursor updates.
    always_comb
    begin
        cnt_next     = cnt_reg;
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        if (cmd.load)
        begin
            cnt_next = '0;
            unique case (in_action)
                ACT_INIT:
                begin
                    cur_col_next = 8'd0;
                    cur_row_next = 2'd0;
                end
                ACT_PUT:
                begin
                    cur_col_next = cur_col_reg + 8'd1;
                end
                ACT_GOTO:
                begin
                    cur_col_next = {2'b00, in_col};
                    cur_row_next = in_row;
                end
                ACT_GLYPH:
                begin
                    cur_col_next = cur_col_reg;
                end
                default:
                begin
                    cur_col_next = cur_col_reg;
                end
            endcase
        end
        else if (cmd.advance)
        begin
            cnt_next = cnt_reg + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            cur_col_reg <= 8'd0;
            cur_row_reg <= 2'd0;
        end
        else
        begin
            cnt_reg     <= cnt_next;
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
        end
    end

    // Byte and nibble selection for the current strobe.
    logic [3:0] byte_idx;
    logic [2:0] bm_idx;
    logic [7:0] cur_byte;
    logic       rs;
    logic       lw;
    logic [3:0] nib;

    assign byte_idx = cnt_reg[4:1];
    assign bm_idx   = 3'(byte_idx - 4'd1);

    always_comb
    begin
        cur_byte = 8'h00;
        rs       = 1'b0;
        lw       = 1'b0;
        unique case (action_reg)
            ACT_INIT:
            begin
                cur_byte = init_byte(byte_idx[2:0]);
                lw       = cnt_reg[0];
            end
            ACT_PUT:
            begin
                cur_byte = char_reg;
                rs       = 1'b1;
            end
            ACT_GOTO:
            begin
                cur_byte = adr_reg;
            end
            ACT_GLYPH:
            begin
                // The CGRAM address goes first, then the bitmap rows as data.
                if (byte_idx == 4'd0)
                begin
                    cur_byte = CGRAM_BASE + {2'b00, slot_reg, 3'b000};
                end
                else
                begin
                    cur_byte = bitmap_reg[{bm_idx, 3'b000} +: 8];
                    rs       = 1'b1;
                end
            end
            default:
            begin
                cur_byte = 8'h00;
            end
        endcase
    end

    // High nibble on even strobes, low nibble on odd ones.
    assign nib = cnt_reg[0] ? cur_byte[3:0] : cur_byte[7:4];

    assign status.last = (cnt_reg == total_reg);
    assign m_tlast     = status.last;
    assign m_tuser     = rs;
    assign m_tdata     = {1'b0, cur_row_reg, cur_col_reg, lw, nib};

endmodule

// ===== hw/rtl/clnw_checker.sv =====
// Port-level checker of the character LCD nibble writer and its bind to the top level.
`timescale 1ns / 1ps
`include "char_lcd_nibble_writer_top_macros.svh"

module clnw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // A stalled strobe word holds.
    `CLNW_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled strobe word changed")

    // One command at a time: no new word while strobes are pending.
    `CLNW_ASSERT_NEVER(a_one_at_a_time, s_tready && m_tvalid, "input ready while strobes pending")

    // An accepted command produces strobes in the next cycle.
    `CLNW_ASSERT(a_start, s_tvalid && s_tready |=> m_tvalid, "no strobe after accepted command")

    // The last strobe ends the command and frees the input.
    `CLNW_ASSERT(a_end, m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid, "command did not end after last strobe")

    // Long waits only follow command-register strobes.
    `CLNW_ASSERT_NEVER(a_wait_cmd_only, m_tvalid && m_tdata[4] && m_tuser, "long wait on a data strobe")

endmodule

bind char_lcd_nibble_writer_top clnw_checker u_clnw_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for the character LCD nibble writer top level.
`timescale 1ns / 1ps

module tb;
    import clnw_pkg::*;

    // One command word waiting to be sent.
    typedef struct {
        action_t     act;
        logic [7:0]  ch;
        logic [5:0]  col;
        logic [1:0]  row;
        logic [2:0]  slot;
        logic [63:0] bitmap;
        bit          drain;
    } lcd_cmd_t;

    // One strobe word as the block should emit it.
    typedef struct {
        logic       rs;
        logic [3:0] nibble;
        logic       long_wait;
        logic       last;
        logic [7:0] ccol;
        logic [1:0] crow;
    } lcd_strobe_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    lcd_cmd_t    cmd_q[$];
    lcd_strobe_t strobe_q[$];

    // Cursor position as the block should track it.
    logic [7:0]  lcd_col = 8'd0;
    logic [1:0]  lcd_row = 2'd0;

    int errors = 0;
    int cmds_sent = 0;
    int strobes_seen = 0;
    int action_count[4] = '{0, 0, 0, 0};
    bit word_taken = 1'b0;
    bit calm;

    char_lcd_nibble_writer_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Both sides run without idle cycles through a late stretch of the run.
    assign calm = (cmds_sent >= 120) && (cmds_sent < 170);

    task automatic report(input string field, input logic [7:0] got, input logic [7:0] want);
        errors++;
        $display("MISMATCH at strobe %0d: %s got %0h, expected %0h",
                 strobes_seen, field, got, want);
    endtask

    // Work out the strobe words of one accepted command and update the cursor.
    task automatic predict_strobes(input action_t act, input logic [87:0] data);
        logic [7:0]  seq_byte[0:8];
        logic        seq_rs[0:8];
        int          nbytes;
        bit          slow;
        logic [7:0]  ch;
        logic [5:0]  col;
        logic [1:0]  row;
        logic [2:0]  slot;
        logic [63:0] bitmap;
        lcd_strobe_t s;
        ch     = data[7:0];
        col    = data[13:8];
        row    = data[15:14];
        slot   = data[18:16];
        bitmap = data[82:19];
        slow   = 1'b0;
        nbytes = 0;
        case (act)
            ACT_INIT:
            begin
                for (int i = 0; i < 6; i++)
                begin
                    seq_rs[i] = 1'b0;
                end
                seq_byte[0] = 8'h20;
                seq_byte[1] = 8'h20;
                seq_byte[2] = 8'h20;
                seq_byte[3] = 8'h28;
                seq_byte[4] = 8'h0C;
                seq_byte[5] = 8'h01;
                nbytes  = 6;
                slow    = 1'b1;
                lcd_col = 8'd0;
                lcd_row = 2'd0;
            end
            ACT_PUT:
            begin
                seq_byte[0] = ch;
                seq_rs[0]   = 1'b1;
                nbytes      = 1;
                lcd_col     = lcd_col + 8'd1;
            end
            ACT_GOTO:
            begin
                // Address wraps in 8 bits, so bad rows and columns still form a byte.
                seq_byte[0] = 8'h80 + ({6'd0, row} - 8'd1) * 8'h40 + {2'd0, col} - 8'd1;
                seq_rs[0]   = 1'b0;
                nbytes      = 1;
                lcd_col     = {2'd0, col};
                lcd_row     = row;
            end
            default:
            begin
                seq_byte[0] = 8'h40 + {2'd0, slot, 3'd0};
                seq_rs[0]   = 1'b0;
                for (int i = 0; i < 8; i++)
                begin
                    seq_byte[i + 1] = bitmap[8 * i +: 8];
                    seq_rs[i + 1]   = 1'b1;
                end
                nbytes = 9;
            end
        endcase
        // High nibble first; only init bytes wait after the low nibble.
        for (int i = 0; i < nbytes; i++)
        begin
            for (int h = 0; h < 2; h++)
            begin
                s.rs        = seq_rs[i];
                s.nibble    = (h == 0) ? seq_byte[i][7:4] : seq_byte[i][3:0];
                s.long_wait = (h == 1) && slow;
                s.last      = (i == nbytes - 1) && (h == 1);
                s.ccol      = lcd_col;
                s.crow      = lcd_row;
                strobe_q.push_back(s);
            end
        end
    endtask

    task automatic queue_cmd(input action_t act, input logic [7:0] ch, input logic [5:0] col,
                             input logic [1:0] row, input logic [2:0] slot,
                             input logic [63:0] bitmap, input bit drain);
        lcd_cmd_t c;
        c.act    = act;
        c.ch     = ch;
        c.col    = col;
        c.row    = row;
        c.slot   = slot;
        c.bitmap = bitmap;
        c.drain  = drain;
        cmd_q.push_back(c);
    endtask

    // Queue a command whose unused fields carry random bits.
    task automatic queue_rand(input action_t act, input bit drain);
        logic [7:0]  ch;
        logic [5:0]  col;
        logic [1:0]  row;
        logic [2:0]  slot;
        logic [63:0] bitmap;
        ch     = 8'($urandom);
        col    = 6'($urandom);
        row    = 2'($urandom);
        slot   = 3'($urandom);
        bitmap = {$urandom, $urandom};
        if ((act == ACT_GOTO) && ($urandom_range(99) < 80))
        begin
            row = 2'($urandom_range(2, 1));
            col = 6'($urandom_range(40, 1));
        end
        queue_cmd(act, ch, col, row, slot, bitmap, drain);
    endtask

    // Driver: offers command words and the output ready at the falling edge.
    always @(negedge clk)
    begin : driver
        lcd_cmd_t c;
        if (rst_n)
        begin
            if (!s_tvalid || word_taken)
            begin
                if ((cmd_q.size() > 0) && !(cmd_q[0].drain && (strobe_q.size() > 0))
                    && (calm || ($urandom_range(99) >= 22)))
                begin
                    c = cmd_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= c.act;
                    s_tdata  <= {5'd0, c.bitmap, c.slot, c.row, c.col, c.ch};
                    cmds_sent++;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= calm || ($urandom_range(99) >= 22);
        end
    end

    // Monitor: records accepted commands and checks every strobe word.
    always @(posedge clk)
    begin : monitor
        lcd_strobe_t want;
        word_taken = 1'b0;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                word_taken = 1'b1;
                action_count[s_tuser]++;
                predict_strobes(action_t'(s_tuser), s_tdata);
            end
            if (m_tvalid && m_tready)
            begin
                strobes_seen++;
                if (strobe_q.size() == 0)
                begin
                    errors++;
                    $display("UNEXPECTED strobe word %0d: tdata %0h tuser %0b tlast %0b",
                             strobes_seen, m_tdata, m_tuser, m_tlast);
                end
                else
                begin
                    want = strobe_q.pop_front();
                    if (m_tuser !== want.rs)
                        report("reg_select", 8'(m_tuser), 8'(want.rs));
                    if (m_tdata[3:0] !== want.nibble)
                        report("nibble", 8'(m_tdata[3:0]), 8'(want.nibble));
                    if (m_tdata[4] !== want.long_wait)
                        report("long_wait", 8'(m_tdata[4]), 8'(want.long_wait));
                    if (m_tlast !== want.last)
                        report("last", 8'(m_tlast), 8'(want.last));
                    if (m_tdata[12:5] !== want.ccol)
                        report("cursor_col", m_tdata[12:5], want.ccol);
                    if (m_tdata[14:13] !== want.crow)
                        report("cursor_row", 8'(m_tdata[14:13]), 8'(want.crow));
                end
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int r;
        // Directed part: each action, field extremes and out-of-range goto targets.
        queue_rand(ACT_INIT, 1'b0);
        queue_cmd(ACT_PUT, 8'h00, 6'd0, 2'd0, 3'd0, 64'd0, 1'b0);
        queue_cmd(ACT_PUT, 8'hFF, 6'h3F, 2'd3, 3'd7, '1, 1'b0);
        queue_cmd(ACT_PUT, 8'hA5, 6'h2A, 2'd1, 3'd5, 64'h5555_5555_5555_5555, 1'b0);
        queue_cmd(ACT_GOTO, 8'h00, 6'd1, 2'd1, 3'd0, 64'd0, 1'b0);
        queue_cmd(ACT_GOTO, 8'hFF, 6'd40, 2'd2, 3'd7, '1, 1'b0);
        queue_cmd(ACT_GOTO, 8'h12, 6'd1, 2'd0, 3'd2, 64'd0, 1'b0);
        queue_cmd(ACT_GOTO, 8'h34, 6'd40, 2'd3, 3'd4, 64'd0, 1'b0);
        queue_cmd(ACT_GOTO, 8'h56, 6'd0, 2'd1, 3'd1, 64'd0, 1'b0);
        queue_cmd(ACT_GOTO, 8'h78, 6'd63, 2'd2, 3'd6, 64'd0, 1'b0);
        queue_cmd(ACT_GOTO, 8'h9A, 6'd0, 2'd0, 3'd3, 64'd0, 1'b0);
        queue_cmd(ACT_GLYPH, 8'h00, 6'd0, 2'd0, 3'd0, 64'd0, 1'b0);
        queue_cmd(ACT_GLYPH, 8'hFF, 6'h3F, 2'd3, 3'd7, '1, 1'b0);
        queue_cmd(ACT_GLYPH, 8'h11, 6'd5, 2'd1, 3'd3, 64'hFEDC_BA98_7654_3210, 1'b0);
        queue_cmd(ACT_GLYPH, 8'h22, 6'd9, 2'd2, 3'd5, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        queue_cmd(ACT_PUT, 8'h5A, 6'h15, 2'd2, 3'd2, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        queue_rand(ACT_INIT, 1'b1);
        // After the output side has drained, jump to the farthest column.
        queue_cmd(ACT_GOTO, 8'h00, 6'd63, 2'd1, 3'd0, 64'd0, 1'b1);
        // Random part with an occasional pause until the output side has drained.
        for (int i = 0; i < 152; i++)
        begin
            r = $urandom_range(99);
            if (r < 10)
                queue_rand(ACT_INIT, ($urandom_range(99) < 4));
            else if (r < 40)
                queue_rand(ACT_PUT, ($urandom_range(99) < 4));
            else if (r < 65)
                queue_rand(ACT_GOTO, ($urandom_range(99) < 4));
            else
                queue_rand(ACT_GLYPH, ($urandom_range(99) < 4));
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while ((cmd_q.size() != 0) || s_tvalid || (strobe_q.size() != 0))
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Covered %0d commands: %0d init, %0d put, %0d goto, %0d glyph.",
                 cmds_sent, action_count[ACT_INIT], action_count[ACT_PUT],
                 action_count[ACT_GOTO], action_count[ACT_GLYPH]);
        $display("Checked %0d strobe words, including odd goto targets and output stalls.",
                 strobes_seen);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #2_000_000;
        $display("Timeout with %0d strobe words still expected.", strobe_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/clnw_pkg.sv
hw/rtl/clnw_ctrl.sv
hw/rtl/clnw_datapath.sv
hw/rtl/char_lcd_nibble_writer_top.sv
hw/rtl/clnw_checker.sv
tb/tb.sv
